// File: sv/rrcs_pkg.sv
// rrcs_pkg: shared types, codes and defaults for the round-robin core scheduler.
// Used by rrcs_ctrl, rrcs_dp and round_robin_core_scheduler; depends on nothing.
package rrcs_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_NCORES   = 8;
  localparam int DEF_NTASKS   = 64;
  localparam int DEF_ID_WIDTH = 16;

  // Fixed field widths of the ports
  localparam int CMD_W     = 2;
  localparam int TASK_ID_W = 16;
  localparam int ACT_W     = 2;
  localparam int CORE_W    = 3;
  localparam int REM_W     = 7;
  localparam int CFG_W     = 4;

  localparam logic [REM_W-1:0] REM_MAX = 7'd127;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_EXIT = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_ACK    = 2'd0,
    ACT_START  = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_REJECT = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD,
    ST_EXIT_RD,
    ST_EXIT_EVAL,
    ST_PRE_RD,
    ST_PRE_EVAL,
    ST_FILL_CHK,
    ST_FILL_USE,
    ST_FINISH
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic add_op;
    logic exit_op;
    logic pre_op;
    logic fill_pop;
    logic finish;
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    cmd_t cmd;
    logic first_tick;
    logic idx_done;
    logic fill_skip;
  } dp_status_t;

endpackage

// File: sv/round_robin_core_scheduler.sv
// round_robin_core_scheduler: top level of the round-robin time-slice scheduler.
// Depends on rrcs_pkg, rrcs_ctrl (sequencer) and rrcs_dp (datapath).

// A command beat is taken when start is high and busy is low. Each command
// gives one or more result beats, each shown for exactly one cycle with
// result_valid high; the receiver cannot stall, so it must take every beat
// as it comes. The final beat of a command has last set; the beats of one
// command are in order and never interleave with another command's beats.
// The work of a command is a per-core scan: each core in use takes a
// slot-memory read state and an evaluate state when preempting or on exit;
// when refilling it takes a check state, then a queue-read use state unless
// the core is occupied or the queue is empty. Result beats pass through a
// one-deep holding stage: each goes out once the next result or the end of
// the command is known, so the final beat appears in the first cycle with
// busy low; a new command may be accepted in that cycle. num_cores is
// written with cfg_we/cfg_data; write it only while the block is idle.
module round_robin_core_scheduler #(
  parameter int NCORES   = rrcs_pkg::DEF_NCORES,
  parameter int NTASKS   = rrcs_pkg::DEF_NTASKS,
  parameter int ID_WIDTH = rrcs_pkg::DEF_ID_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [rrcs_pkg::CMD_W-1:0]     command,
  input  logic [rrcs_pkg::TASK_ID_W-1:0] task_id,
  // configuration
  input  logic                           cfg_we,
  input  logic [rrcs_pkg::CFG_W-1:0]     cfg_data,
  // result channel
  output logic                           result_valid,
  output logic [rrcs_pkg::ACT_W-1:0]     action,
  output logic [rrcs_pkg::TASK_ID_W-1:0] task_id_res,
  output logic [rrcs_pkg::CORE_W-1:0]    core,
  output logic [rrcs_pkg::REM_W-1:0]     remaining,
  output logic                           last
);
  import rrcs_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequencer: dispatch, per-core exit/preempt/refill scans, finish
  rrcs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (dp_status),
    .cmd    (dp_cmd),
    .busy   (busy)
  );

  // Queue, slots, counters and result registers
  rrcs_dp #(
    .NCORES   (NCORES),
    .NTASKS   (NTASKS),
    .ID_WIDTH (ID_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (dp_cmd),
    .status       (dp_status),
    .command      (command),
    .task_id      (task_id),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .action       (action),
    .task_id_res  (task_id_res),
    .core         (core),
    .remaining    (remaining),
    .last         (last)
  );

endmodule

// File: sv/rrcs_ctrl.sv
// rrcs_ctrl: sequencing state machine of the scheduler.
// Depends on rrcs_pkg; drives rrcs_dp through dp_cmd_t and reads dp_status_t.
module rrcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rrcs_pkg::dp_status_t status,
  output rrcs_pkg::dp_cmd_t    cmd,
  output logic                busy
);
  import rrcs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (status.cmd)
          CMD_ADD:  state_next = ST_ADD;
          CMD_EXIT: state_next = ST_EXIT_RD;
          CMD_TICK: state_next = status.first_tick ? ST_FILL_CHK : ST_PRE_RD;
          CMD_NOP:  state_next = ST_FINISH;
          default:  state_next = ST_FINISH;
        endcase
      end
      ST_ADD:       state_next = ST_FINISH;
      ST_EXIT_RD:   state_next = status.idx_done ? ST_FINISH : ST_EXIT_EVAL;
      ST_EXIT_EVAL: state_next = ST_EXIT_RD;
      ST_PRE_RD:    state_next = status.idx_done ? ST_FILL_CHK : ST_PRE_EVAL;
      ST_PRE_EVAL:  state_next = ST_PRE_RD;
      ST_FILL_CHK: begin
        priority if (status.idx_done) state_next = ST_FINISH;
        else if (status.fill_skip)    state_next = ST_FILL_CHK;
        else                          state_next = ST_FILL_USE;
      end
      ST_FILL_USE:  state_next = ST_FILL_CHK;
      ST_FINISH:    state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_DISPATCH: ;
      ST_ADD:      cmd.add_op = 1'b1;
      ST_EXIT_RD:  ;
      ST_EXIT_EVAL: begin
        cmd.exit_op = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      ST_PRE_RD: begin
        cmd.idx_clr = status.idx_done;
      end
      ST_PRE_EVAL: begin
        cmd.pre_op  = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      ST_FILL_CHK: begin
        cmd.idx_inc = !status.idx_done && status.fill_skip;
      end
      ST_FILL_USE: begin
        cmd.fill_pop = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      ST_FINISH:   cmd.finish = 1'b1;
      default:     ;
    endcase
  end

endmodule

// File: sv/rrcs_dp.sv
// rrcs_dp: scheduler datapath - ready queue memory, core slot store, counters,
// one-deep result holding stage and registered result ports. Depends on rrcs_pkg.
module rrcs_dp #(
  parameter int NCORES   = rrcs_pkg::DEF_NCORES,
  parameter int NTASKS   = rrcs_pkg::DEF_NTASKS,
  parameter int ID_WIDTH = rrcs_pkg::DEF_ID_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rrcs_pkg::dp_cmd_t                 cmd,
  output rrcs_pkg::dp_status_t              status,
  input  logic [rrcs_pkg::CMD_W-1:0]        command,
  input  logic [rrcs_pkg::TASK_ID_W-1:0]    task_id,
  input  logic                              cfg_we,
  input  logic [rrcs_pkg::CFG_W-1:0]        cfg_data,
  output logic                              result_valid,
  output logic [rrcs_pkg::ACT_W-1:0]        action,
  output logic [rrcs_pkg::TASK_ID_W-1:0]    task_id_res,
  output logic [rrcs_pkg::CORE_W-1:0]       core,
  output logic [rrcs_pkg::REM_W-1:0]        remaining,
  output logic                              last
);
  import rrcs_pkg::*;

  localparam int IW  = (NCORES > 1) ? $clog2(NCORES) : 1;
  localparam int CW  = $clog2(NCORES + 1);
  localparam int QW  = $clog2(NTASKS);
  localparam int QCW = $clog2(NTASKS + 1);

  // Configuration and long-lived state
  logic [CFG_W-1:0]  num_cores;
  logic              first_tick;
  logic [REM_W-1:0]  rem;
  logic [QW-1:0]     q_head;
  logic [QW-1:0]     q_tail;
  logic [QCW-1:0]    q_count;
  logic [NCORES-1:0] occ;

  // Per-item registers
  cmd_t              cur_cmd;
  logic              cur_first;
  logic [ID_WIDTH-1:0] cur_id;
  logic [CW-1:0]     nc;
  logic [CW-1:0]     idx;

  // Memories with registered read
  logic [ID_WIDTH:0]   q_mem [NTASKS];
  logic [ID_WIDTH:0]   q_rd;
  logic [ID_WIDTH-1:0] slot_mem [NCORES];
  logic [ID_WIDTH-1:0] slot_rd;

  // Holding stage
  logic                pend_valid;
  act_t                pend_act;
  logic [ID_WIDTH-1:0] pend_id;
  logic [IW-1:0]       pend_core;

  logic [IW-1:0]       cidx;
  logic                q_full;
  logic                q_empty;
  logic [ID_WIDTH+TASK_ID_W-1:0] in_wide;
  logic [ID_WIDTH-1:0] in_id;
  logic [CW-1:0]       nc_cfg;
  logic                q_rd_done;
  logic [ID_WIDTH-1:0] q_rd_id;
  logic                exit_hit;
  logic                pre_hit;
  logic                fill_take;
  logic                push;
  logic                push_done;
  logic [ID_WIDTH-1:0] push_id;
  logic                emit;
  act_t                emit_act;
  logic [ID_WIDTH-1:0] emit_id;
  logic [IW-1:0]       emit_core;
  act_t                out_act;
  logic [ID_WIDTH-1:0] out_id;
  logic [IW-1:0]       out_core;
  logic [ID_WIDTH+TASK_ID_W-1:0] out_id_wide;
  logic [IW+CORE_W-1:0] out_core_wide;

  assign cidx      = idx[IW-1:0];
  assign q_full    = (q_count == QCW'(NTASKS));
  assign q_empty   = (q_count == '0);
  assign in_wide   = {{ID_WIDTH{1'b0}}, task_id};
  assign in_id     = in_wide[ID_WIDTH-1:0];
  assign q_rd_done = q_rd[ID_WIDTH];
  assign q_rd_id   = q_rd[ID_WIDTH-1:0];

  always_comb begin
    priority if (num_cores == '0)       nc_cfg = CW'(1);
    else if (int'(num_cores) > NCORES)  nc_cfg = CW'(NCORES);
    else                                nc_cfg = CW'(num_cores);
  end

  // Per-core decisions
  assign exit_hit  = cmd.exit_op && occ[cidx] && (slot_rd == cur_id);
  assign pre_hit   = cmd.pre_op && !q_empty && !q_full && occ[cidx];
  assign fill_take = cmd.fill_pop && !q_rd_done;
  assign push      = (cmd.add_op && !q_full) || (exit_hit && !q_full) || pre_hit;
  assign push_done = exit_hit;
  assign push_id   = pre_hit ? slot_rd : cur_id;
  assign emit      = cmd.add_op || exit_hit || pre_hit || fill_take;

  always_comb begin
    priority if (cmd.add_op) begin
      emit_act  = q_full ? ACT_REJECT : ACT_ACK;
      emit_id   = cur_id;
      emit_core = '0;
    end else if (fill_take) begin
      emit_act  = ACT_START;
      emit_id   = q_rd_id;
      emit_core = cidx;
    end else begin
      emit_act  = ACT_STOP;
      emit_id   = pre_hit ? slot_rd : cur_id;
      emit_core = cidx;
    end
  end

  assign status.cmd        = cur_cmd;
  assign status.first_tick = cur_first;
  assign status.idx_done   = (idx == nc);
  assign status.fill_skip  = occ[cidx] || q_empty;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cores <= CFG_W'(1);
    end else if (cfg_we) begin
      num_cores <= cfg_data;
    end
  end

  // Item latch, loop counter, tick flag, remaining count
  always_ff @(posedge clk) begin
    if (rst) begin
      first_tick <= 1'b1;
      rem        <= '0;
      idx        <= '0;
      nc         <= CW'(1);
      cur_cmd    <= CMD_NOP;
      cur_first  <= 1'b0;
    end else if (cmd.load) begin
      cur_cmd   <= cmd_t'(command);
      cur_id    <= in_id;
      cur_first <= first_tick;
      nc        <= nc_cfg;
      idx       <= '0;
      if (cmd_t'(command) == CMD_TICK) first_tick <= 1'b0;
      if (cmd_t'(command) == CMD_ADD && !q_full && rem != REM_MAX) rem <= rem + 1'b1;
      if (cmd_t'(command) == CMD_EXIT && rem != '0) rem <= rem - 1'b1;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // Ready queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else if (push) begin
      q_tail  <= (q_tail == QW'(NTASKS - 1)) ? '0 : q_tail + 1'b1;
      q_count <= q_count + 1'b1;
    end else if (cmd.fill_pop) begin
      q_head  <= (q_head == QW'(NTASKS - 1)) ? '0 : q_head + 1'b1;
      q_count <= q_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[q_tail] <= {push_done, push_id};
    q_rd <= q_mem[q_head];
  end

  // Core slots: occupied flags in flops, task ids in a small memory
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (exit_hit || pre_hit) begin
      occ[cidx] <= 1'b0;
    end else if (fill_take) begin
      occ[cidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_take) slot_mem[cidx] <= q_rd_id;
    slot_rd <= slot_mem[cidx];
  end

  // Result holding stage: a result goes out once the next one (or the end) is known
  always_comb begin
    if (pend_valid) begin
      out_act  = pend_act;
      out_id   = pend_id;
      out_core = pend_core;
    end else begin
      out_act  = ACT_ACK;
      out_id   = (cur_cmd == CMD_TICK) ? '0 : cur_id;
      out_core = '0;
    end
  end

  assign out_id_wide   = {{TASK_ID_W{1'b0}}, out_id};
  assign out_core_wide = {{CORE_W{1'b0}}, out_core};
  assign remaining     = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (emit && pend_valid) || cmd.finish;
      if (emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pend_act  <= emit_act;
      pend_id   <= emit_id;
      pend_core <= emit_core;
    end
    if (emit || cmd.finish) begin
      action      <= out_act;
      task_id_res <= out_id_wide[TASK_ID_W-1:0];
      core        <= out_core_wide[CORE_W-1:0];
      last        <= cmd.finish;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCW'(NTASKS))
    else $error("ready queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (q_count == '0) |-> (q_head == q_tail))
    else $error("empty queue with head and tail apart");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !result_valid)
    else $error("result beat right after a final beat");

  a_emit_finish: assert property (@(posedge clk) disable iff (rst)
    !(emit && cmd.finish))
    else $error("result produced in the finishing cycle");

endmodule
